>>> sv/dtoa_pkg.sv
`timescale 1ns / 1ps

package dtoa_pkg;

   localparam int STEP_W    = 5;
   localparam int X_W       = 17;
   localparam int RCP_W     = 14;
   localparam int PROD_W    = X_W + RCP_W;
   localparam int Q_W       = PROD_W - X_W;
   localparam int R_W       = 10;
   localparam int C_W       = 9;
   localparam int YEAR_W    = 17;
   localparam int MONTH_W   = 9;
   localparam int DAY_W     = 13;
   localparam int HOUR_W    = 13;
   localparam int MIN_W     = 17;
   localparam int SEC_W     = 17;
   localparam int Y400_W    = 9;

   typedef enum logic [2:0] {
      OP_MUL  = 3'd0,
      OP_QR   = 3'd1,
      OP_FIX  = 3'd2,
      OP_WALK = 3'd3,
      OP_DONE = 3'd4
   } dtoa_op_type;

   typedef enum logic [2:0] {
      UNIT_SEC  = 3'd0,
      UNIT_MIN  = 3'd1,
      UNIT_HOUR = 3'd2,
      UNIT_MON  = 3'd3,
      UNIT_YEAR = 3'd4
   } dtoa_unit_type;

   typedef enum logic [1:0] {
      DIV_60  = 2'd0,
      DIV_24  = 2'd1,
      DIV_12  = 2'd2,
      DIV_400 = 2'd3
   } dtoa_div_type;

   typedef enum logic [1:0] {
      JC_NEVER    = 2'd0,
      JC_DAY_OVER = 2'd1,
      JC_OUT_FULL = 2'd2
   } dtoa_jc_type;

   typedef struct packed {
      dtoa_op_type         op;
      dtoa_unit_type       unit;
      dtoa_div_type        div;
      dtoa_jc_type         jc;
      logic [STEP_W-1:0]   target;
   } dtoa_ucode_type;

   localparam logic [STEP_W-1:0] STEP_WALK = STEP_W'(15);
   localparam logic [STEP_W-1:0] STEP_DONE = STEP_W'(16);

   function automatic dtoa_ucode_type uword(dtoa_op_type op, dtoa_unit_type unit,
                                            dtoa_div_type div, dtoa_jc_type jc,
                                            logic [STEP_W-1:0] target);
      dtoa_ucode_type w;
      w.op     = op;
      w.unit   = unit;
      w.div    = div;
      w.jc     = jc;
      w.target = target;
      return w;
   endfunction

   // Normalization program: three steps per constant division, then the month walk.
   function automatic dtoa_ucode_type ucode_rom(logic [STEP_W-1:0] step);
      dtoa_ucode_type w;
      unique case (step)
         5'd0:    w = uword(OP_MUL, UNIT_SEC, DIV_60, JC_NEVER, '0);
         5'd1:    w = uword(OP_QR, UNIT_SEC, DIV_60, JC_NEVER, '0);
         5'd2:    w = uword(OP_FIX, UNIT_SEC, DIV_60, JC_NEVER, '0);
         5'd3:    w = uword(OP_MUL, UNIT_MIN, DIV_60, JC_NEVER, '0);
         5'd4:    w = uword(OP_QR, UNIT_MIN, DIV_60, JC_NEVER, '0);
         5'd5:    w = uword(OP_FIX, UNIT_MIN, DIV_60, JC_NEVER, '0);
         5'd6:    w = uword(OP_MUL, UNIT_HOUR, DIV_24, JC_NEVER, '0);
         5'd7:    w = uword(OP_QR, UNIT_HOUR, DIV_24, JC_NEVER, '0);
         5'd8:    w = uword(OP_FIX, UNIT_HOUR, DIV_24, JC_NEVER, '0);
         5'd9:    w = uword(OP_MUL, UNIT_MON, DIV_12, JC_NEVER, '0);
         5'd10:   w = uword(OP_QR, UNIT_MON, DIV_12, JC_NEVER, '0);
         5'd11:   w = uword(OP_FIX, UNIT_MON, DIV_12, JC_NEVER, '0);
         5'd12:   w = uword(OP_MUL, UNIT_YEAR, DIV_400, JC_NEVER, '0);
         5'd13:   w = uword(OP_QR, UNIT_YEAR, DIV_400, JC_NEVER, '0);
         5'd14:   w = uword(OP_FIX, UNIT_YEAR, DIV_400, JC_NEVER, '0);
         5'd15:   w = uword(OP_WALK, UNIT_MON, DIV_12, JC_DAY_OVER, STEP_WALK);
         default: w = uword(OP_DONE, UNIT_MON, DIV_12, JC_OUT_FULL, STEP_DONE);
      endcase
      return w;
   endfunction

   // floor(2**X_W / divisor): the estimate is at most one below the true quotient
   function automatic logic [RCP_W-1:0] recip(dtoa_div_type div);
      logic [RCP_W-1:0] r;
      unique case (div)
         DIV_60:  r = RCP_W'(2184);
         DIV_24:  r = RCP_W'(5461);
         DIV_12:  r = RCP_W'(10922);
         default: r = RCP_W'(327);
      endcase
      return r;
   endfunction

   function automatic logic [C_W-1:0] div_const(dtoa_div_type div);
      logic [C_W-1:0] c;
      unique case (div)
         DIV_60:  c = C_W'(60);
         DIV_24:  c = C_W'(24);
         DIV_12:  c = C_W'(12);
         default: c = C_W'(400);
      endcase
      return c;
   endfunction

   function automatic logic is_leap(logic [Y400_W-1:0] y400);
      return (y400 == '0) ||
             ((y400[1:0] == 2'd0) && (y400 != Y400_W'(100)) &&
              (y400 != Y400_W'(200)) && (y400 != Y400_W'(300)));
   endfunction

   function automatic logic [4:0] month_len(logic [3:0] m, logic leap);
      logic [4:0] n;
      case (m) inside
         4'd2:                   n = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
         default:                n = 5'd31;
      endcase
      return n;
   endfunction

endpackage

>>> sv/dtoa_cdiv.sv
`timescale 1ns / 1ps

module dtoa_cdiv
   import dtoa_pkg::*;
(
   input  logic           clock,
   input  dtoa_ucode_type ctl,
   input  logic [X_W-1:0] x,
   output logic [Q_W-1:0] q,
   output logic [R_W-1:0] r
);

   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [Q_W-1:0]       q_ff;
   logic [R_W-1:0]       r_ff, r_in;
   logic [Q_W-1:0]       q_est;
   logic [C_W-1:0]       c;
   logic [Q_W+C_W-1:0]   qc;
   logic [Q_W+C_W-1:0]   diff;

   assign c       = div_const(ctl.div);
   assign prod_in = PROD_W'(x) * PROD_W'(recip(ctl.div));
   assign q_est   = prod_ff[PROD_W-1 -: Q_W];
   assign qc      = (Q_W+C_W)'(q_est) * (Q_W+C_W)'(c);
   assign diff    = (Q_W+C_W)'(x) - qc;
   // remainder is below twice the divisor, so the low bits carry it
   assign r_in    = diff[R_W-1:0];

   always_ff @(posedge clock) begin
      if (ctl.op == OP_MUL) begin
         prod_ff <= prod_in;
      end
      if (ctl.op == OP_QR) begin
         q_ff <= q_est;
         r_ff <= r_in;
      end
   end

   // correct an estimate that came out one low
   always_comb begin
      if (r_ff >= R_W'(c)) begin
         r = r_ff - R_W'(c);
         q = q_ff + Q_W'(1);
      end else begin
         r = r_ff;
         q = q_ff;
      end
   end

endmodule

>>> sv/date_time_offset_adder_core.sv
`timescale 1ns / 1ps

// Date-time offset adder: adds year/month/day/hour/minute/second offsets to a
// calendar date-time and normalizes with Gregorian carries.
// Request channel (req_valid/req_ready): one word holds the base date-time and
// six signed offsets; a negative offset leaves its unit unchanged.
// Response channel (rsp_valid/rsp_ready): one word per request with the
// normalized date-time and a year overflow flag (year saturates at 65535).
// The program runs five constant divisions on one shared multiply-based divider,
// three program steps each, then a walk that subtracts one month per cycle from
// the day count (0 up to about 142 whole months) before the final step.
// One request is in flight at a time; req_ready returns together with rsp_valid,
// when the result moves into the output register.
// A finished result waits in the output register while the receiver stalls;
// the next request may be accepted and worked on meanwhile, and holds at the
// final step until the output register frees.
// Reset (synchronous) clears the busy flag, the step counter and rsp_valid.
module date_time_offset_adder_core
   import dtoa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_base_year,
   input  logic [3:0]  req_base_month,
   input  logic [4:0]  req_base_day,
   input  logic [4:0]  req_base_hour,
   input  logic [5:0]  req_base_minute,
   input  logic [5:0]  req_base_second,
   input  logic signed [8:0]  req_add_years,
   input  logic signed [8:0]  req_add_months,
   input  logic signed [12:0] req_add_days,
   input  logic signed [12:0] req_add_hours,
   input  logic signed [16:0] req_add_minutes,
   input  logic signed [16:0] req_add_seconds,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_sum_year,
   output logic [3:0]  rsp_sum_month,
   output logic [4:0]  rsp_sum_day,
   output logic [4:0]  rsp_sum_hour,
   output logic [5:0]  rsp_sum_minute,
   output logic [5:0]  rsp_sum_second,
   output logic        rsp_year_overflow
);

   logic                 busy_ff, busy_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [YEAR_W-1:0]    year_ff, year_in;
   logic [MONTH_W-1:0]   month_ff, month_in;
   logic [DAY_W-1:0]     day_ff, day_in;
   logic [HOUR_W-1:0]    hour_ff, hour_in;
   logic [MIN_W-1:0]     min_ff, min_in;
   logic [SEC_W-1:0]     sec_ff, sec_in;
   logic [Y400_W-1:0]    y400_ff, y400_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [15:0]          o_year_ff;
   logic [3:0]           o_month_ff;
   logic [4:0]           o_day_ff;
   logic [4:0]           o_hour_ff;
   logic [5:0]           o_min_ff;
   logic [5:0]           o_sec_ff;
   logic                 o_ovf_ff;

   dtoa_ucode_type       uw;
   logic                 accept;
   logic                 out_full;
   logic                 out_load;
   logic [X_W-1:0]       div_x;
   logic [Q_W-1:0]       div_q;
   logic [R_W-1:0]       div_r;
   logic [4:0]           mlen;
   logic                 day_over;
   logic [3:0]           month0;
   logic [4:0]           day0;

   assign uw        = ucode_rom(step_ff);
   assign req_ready = !busy_ff && !reset;
   assign accept    = req_valid && req_ready;
   assign out_full  = rsp_valid_ff && !rsp_ready;
   assign out_load  = busy_ff && (uw.op == OP_DONE) && !out_full;

   assign month0 = (req_base_month == 4'd0) ? 4'd1 : req_base_month;
   assign day0   = (req_base_day == 5'd0) ? 5'd1 : req_base_day;

   assign mlen     = month_len(month_ff[3:0], is_leap(y400_ff));
   assign day_over = day_ff > DAY_W'(mlen);

   always_comb begin
      case (uw.unit)
         UNIT_SEC:  div_x = sec_ff;
         UNIT_MIN:  div_x = min_ff;
         UNIT_HOUR: div_x = X_W'(hour_ff);
         UNIT_MON:  div_x = X_W'(month_ff - MONTH_W'(1));
         default:   div_x = year_ff;
      endcase
   end

   dtoa_cdiv u_cdiv (
      .clock (clock),
      .ctl   (uw),
      .x     (div_x),
      .q     (div_q),
      .r     (div_r)
   );

   always_comb begin
      busy_in  = busy_ff;
      step_in  = step_ff;
      year_in  = year_ff;
      month_in = month_ff;
      day_in   = day_ff;
      hour_in  = hour_ff;
      min_in   = min_ff;
      sec_in   = sec_ff;
      y400_in  = y400_ff;

      if (accept) begin
         busy_in  = 1'b1;
         step_in  = '0;
         year_in  = YEAR_W'(req_base_year) +
                    YEAR_W'(req_add_years[8] ? 8'd0 : req_add_years[7:0]);
         month_in = MONTH_W'(month0) +
                    MONTH_W'(req_add_months[8] ? 8'd0 : req_add_months[7:0]);
         day_in   = DAY_W'(day0) +
                    DAY_W'(req_add_days[12] ? 12'd0 : req_add_days[11:0]);
         hour_in  = HOUR_W'(req_base_hour) +
                    HOUR_W'(req_add_hours[12] ? 12'd0 : req_add_hours[11:0]);
         min_in   = MIN_W'(req_base_minute) +
                    MIN_W'(req_add_minutes[16] ? 16'd0 : req_add_minutes[15:0]);
         sec_in   = SEC_W'(req_base_second) +
                    SEC_W'(req_add_seconds[16] ? 16'd0 : req_add_seconds[15:0]);
      end else if (busy_ff) begin
         unique case (uw.op)
            OP_FIX: begin
               // keep the remainder, carry the quotient up one unit (the year keeps only y400)
               case (uw.unit)
                  UNIT_SEC: begin
                     sec_in = SEC_W'(div_r);
                     min_in = min_ff + MIN_W'(div_q);
                  end
                  UNIT_MIN: begin
                     min_in  = MIN_W'(div_r);
                     hour_in = hour_ff + HOUR_W'(div_q);
                  end
                  UNIT_HOUR: begin
                     hour_in = HOUR_W'(div_r);
                     day_in  = day_ff + DAY_W'(div_q);
                  end
                  UNIT_MON: begin
                     month_in = MONTH_W'(div_r) + MONTH_W'(1);
                     year_in  = year_ff + YEAR_W'(div_q);
                  end
                  default: begin
                     y400_in = Y400_W'(div_r);
                  end
               endcase
            end
            OP_WALK: begin
               if (day_over) begin
                  day_in = day_ff - DAY_W'(mlen);
                  if (month_ff == MONTH_W'(12)) begin
                     month_in = MONTH_W'(1);
                     year_in  = year_ff + YEAR_W'(1);
                     y400_in  = (y400_ff == Y400_W'(399)) ? '0 : y400_ff + Y400_W'(1);
                  end else begin
                     month_in = month_ff + MONTH_W'(1);
                  end
               end
            end
            OP_DONE: begin
               if (!out_full) begin
                  busy_in = 1'b0;
               end
            end
            default: begin
            end
         endcase

         unique case (uw.jc)
            JC_DAY_OVER: step_in = day_over ? uw.target : step_ff + STEP_W'(1);
            JC_OUT_FULL: step_in = out_full ? uw.target : '0;
            default:     step_in = step_ff + STEP_W'(1);
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      year_ff  <= year_in;
      month_ff <= month_in;
      day_ff   <= day_in;
      hour_ff  <= hour_in;
      min_ff   <= min_in;
      sec_ff   <= sec_in;
      y400_ff  <= y400_in;
      if (out_load) begin
         // saturate the year; month and day already used the full year
         o_year_ff  <= year_ff[YEAR_W-1] ? 16'hFFFF : year_ff[15:0];
         o_ovf_ff   <= year_ff[YEAR_W-1];
         o_month_ff <= month_ff[3:0];
         o_day_ff   <= day_ff[4:0];
         o_hour_ff  <= hour_ff[4:0];
         o_min_ff   <= min_ff[5:0];
         o_sec_ff   <= sec_ff[5:0];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sum_year      = o_year_ff;
   assign rsp_sum_month     = o_month_ff;
   assign rsp_sum_day       = o_day_ff;
   assign rsp_sum_hour      = o_hour_ff;
   assign rsp_sum_minute    = o_min_ff;
   assign rsp_sum_second    = o_sec_ff;
   assign rsp_year_overflow = o_ovf_ff;

endmodule

>>> sv/dtoa_checker.sv
`timescale 1ns / 1ps

module dtoa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [15:0] req_base_year,
   input logic [3:0]  req_base_month,
   input logic [4:0]  req_base_day,
   input logic [4:0]  req_base_hour,
   input logic [5:0]  req_base_minute,
   input logic [5:0]  req_base_second,
   input logic signed [8:0]  req_add_years,
   input logic signed [8:0]  req_add_months,
   input logic signed [12:0] req_add_days,
   input logic signed [12:0] req_add_hours,
   input logic signed [16:0] req_add_minutes,
   input logic signed [16:0] req_add_seconds,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_sum_year,
   input logic [3:0]  rsp_sum_month,
   input logic [4:0]  rsp_sum_day,
   input logic [4:0]  rsp_sum_hour,
   input logic [5:0]  rsp_sum_minute,
   input logic [5:0]  rsp_sum_second,
   input logic        rsp_year_overflow
);

   // a stalled result holds its year, month, day and overflow flag
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sum_year) &&
      $stable(rsp_sum_month) && $stable(rsp_sum_day) && $stable(rsp_year_overflow))
      else $error("response word changed while stalled");

   // one request in flight: ready drops after every accepted word
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in flight");

   a_ovf_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_year_overflow |-> rsp_sum_year == 16'hFFFF)
      else $error("overflow without saturated year");

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sum_hour < 5'd24 && rsp_sum_minute < 6'd60 &&
      rsp_sum_second < 6'd60)
      else $error("time field not normalized");

   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sum_month >= 4'd1 && rsp_sum_month <= 4'd12 &&
      rsp_sum_day >= 5'd1 && rsp_sum_day <= 5'd31)
      else $error("date field not normalized");

endmodule

bind date_time_offset_adder_core dtoa_checker u_dtoa_checker (.*);

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

   typedef struct {
      logic [15:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [8:0]  add_years;
      logic [8:0]  add_months;
      logic [12:0] add_days;
      logic [12:0] add_hours;
      logic [16:0] add_minutes;
      logic [16:0] add_seconds;
   } offset_req_type;

   typedef struct {
      logic [15:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic        overflow;
   } datetime_sum_type;

   class sum_scoreboard;
      datetime_sum_type expected_sums[$];
      int mismatches;
      int compared;
      int overflows;

      function int pending();
         return expected_sums.size();
      endfunction

      function bit leap_year(int unsigned y);
         if (y % 400 == 0) return 1'b1;
         if (y % 100 == 0) return 1'b0;
         return (y % 4 == 0);
      endfunction

      function int unsigned days_in_month(int unsigned m, int unsigned y);
         case (m)
            2: return leap_year(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default: return 31;
         endcase
      endfunction

      // any offset with its sign bit set counts as zero
      function int unsigned offset_value(logic [16:0] raw, int unsigned width);
         if (raw[width-1]) return 0;
         return raw;
      endfunction

      function datetime_sum_type add_and_normalize(offset_req_type r);
         int unsigned year, month, day, hour, minute, second;
         datetime_sum_type s;
         year   = r.year;
         month  = (r.month == 0) ? 1 : r.month;
         day    = (r.day == 0) ? 1 : r.day;
         hour   = r.hour;
         minute = r.minute;
         second = r.second;
         year   += offset_value(r.add_years, 9);
         month  += offset_value(r.add_months, 9);
         day    += offset_value(r.add_days, 13);
         hour   += offset_value(r.add_hours, 13);
         minute += offset_value(r.add_minutes, 17);
         second += offset_value(r.add_seconds, 17);
         minute += second / 60;  second = second % 60;
         hour   += minute / 60;  minute = minute % 60;
         day    += hour / 24;    hour   = hour % 24;
         year   += (month - 1) / 12;
         month   = (month - 1) % 12 + 1;
         // walk whole months with the unsaturated year
         while (day > days_in_month(month, year)) begin
            day -= days_in_month(month, year);
            month++;
            if (month > 12) begin
               month = 1;
               year++;
            end
         end
         s.overflow = (year > 65535);
         s.year     = s.overflow ? 16'hFFFF : year[15:0];
         s.month    = month[3:0];
         s.day      = day[4:0];
         s.hour     = hour[4:0];
         s.minute   = minute[5:0];
         s.second   = second[5:0];
         return s;
      endfunction

      function void note_request(offset_req_type r);
         expected_sums.push_back(add_and_normalize(r));
      endfunction

      task report(string what, int unsigned got, int unsigned want);
         if (mismatches < 30)
            $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
         mismatches++;
      endtask

      task check_sum(datetime_sum_type got);
         datetime_sum_type want;
         if (expected_sums.size() == 0) begin
            report("word with no request pending", got.year, 0);
            return;
         end
         want = expected_sums.pop_front();
         compared++;
         if (want.overflow) overflows++;
         if (got.year != want.year) report("sum_year", got.year, want.year);
         if (got.month != want.month) report("sum_month", got.month, want.month);
         if (got.day != want.day) report("sum_day", got.day, want.day);
         if (got.hour != want.hour) report("sum_hour", got.hour, want.hour);
         if (got.minute != want.minute) report("sum_minute", got.minute, want.minute);
         if (got.second != want.second) report("sum_second", got.second, want.second);
         if (got.overflow != want.overflow)
            report("year_overflow", got.overflow, want.overflow);
      endtask
   endclass

   localparam int RANDOM_ITEMS = 1950;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_base_year = '0;
   logic [3:0]  req_base_month = '0;
   logic [4:0]  req_base_day = '0;
   logic [4:0]  req_base_hour = '0;
   logic [5:0]  req_base_minute = '0;
   logic [5:0]  req_base_second = '0;
   logic signed [8:0]  req_add_years = '0;
   logic signed [8:0]  req_add_months = '0;
   logic signed [12:0] req_add_days = '0;
   logic signed [12:0] req_add_hours = '0;
   logic signed [16:0] req_add_minutes = '0;
   logic signed [16:0] req_add_seconds = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_sum_year;
   logic [3:0]  rsp_sum_month;
   logic [4:0]  rsp_sum_day;
   logic [4:0]  rsp_sum_hour;
   logic [5:0]  rsp_sum_minute;
   logic [5:0]  rsp_sum_second;
   logic        rsp_year_overflow;

   sum_scoreboard sums = new();
   bit send_burst = 1'b0;
   bit take_burst = 1'b0;
   int requests_sent = 0;

   date_time_offset_adder_core DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_base_year     (req_base_year),
      .req_base_month    (req_base_month),
      .req_base_day      (req_base_day),
      .req_base_hour     (req_base_hour),
      .req_base_minute   (req_base_minute),
      .req_base_second   (req_base_second),
      .req_add_years     (req_add_years),
      .req_add_months    (req_add_months),
      .req_add_days      (req_add_days),
      .req_add_hours     (req_add_hours),
      .req_add_minutes   (req_add_minutes),
      .req_add_seconds   (req_add_seconds),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_sum_year      (rsp_sum_year),
      .rsp_sum_month     (rsp_sum_month),
      .rsp_sum_day       (rsp_sum_day),
      .rsp_sum_hour      (rsp_sum_hour),
      .rsp_sum_minute    (rsp_sum_minute),
      .rsp_sum_second    (rsp_sum_second),
      .rsp_year_overflow (rsp_year_overflow)
   );

   always #5 clock = ~clock;

   function automatic offset_req_type make_request(int y, int mo, int d, int h, int mi, int s,
                                                   int ay, int am, int ad, int ah,
                                                   int amin, int asec);
      offset_req_type r;
      r.year        = 16'(y);
      r.month       = 4'(mo);
      r.day         = 5'(d);
      r.hour        = 5'(h);
      r.minute      = 6'(mi);
      r.second      = 6'(s);
      r.add_years   = 9'(ay);
      r.add_months  = 9'(am);
      r.add_days    = 13'(ad);
      r.add_hours   = 13'(ah);
      r.add_minutes = 17'(amin);
      r.add_seconds = 17'(asec);
      return r;
   endfunction

   // mostly small offsets, with skip codes, other negatives and full range mixed in
   function automatic logic [16:0] random_offset(int unsigned width, int unsigned small_max);
      logic [16:0] mask;
      logic [16:0] v;
      int unsigned pick;
      mask = (17'h1 << width) - 17'h1;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         v = mask;
      end else if (pick == 1) begin
         v = 17'($urandom);
         v[width-1] = 1'b1;
      end else if (pick <= 7) begin
         v = 17'($urandom_range(0, small_max));
      end else begin
         v = 17'($urandom);
         v[width-1] = 1'b0;
      end
      return v & mask;
   endfunction

   function automatic offset_req_type random_request();
      offset_req_type r;
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick == 0)
         r.year = 16'(65535 - $urandom_range(0, 300));
      else if (pick == 1)
         r.year = 16'(400 * $urandom_range(0, 163) + 100 * $urandom_range(0, 3)
                      - $urandom_range(0, 1));
      else if (pick == 2)
         r.year = 16'($urandom_range(0, 10));
      else
         r.year = 16'($urandom_range(0, 65535));
      r.month  = ($urandom_range(0, 6) == 0) ? 4'($urandom_range(0, 15))
                                             : 4'($urandom_range(1, 12));
      r.day    = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                             : 5'($urandom_range(1, 28));
      r.hour   = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                             : 5'($urandom_range(0, 23));
      r.minute = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                             : 6'($urandom_range(0, 59));
      r.second = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                             : 6'($urandom_range(0, 59));
      r.add_years   = 9'(random_offset(9, 40));
      r.add_months  = 9'(random_offset(9, 30));
      r.add_days    = 13'(random_offset(13, 70));
      r.add_hours   = 13'(random_offset(13, 60));
      r.add_minutes = random_offset(17, 200);
      r.add_seconds = random_offset(17, 200);
      return r;
   endfunction

   task automatic send_request(offset_req_type r);
      int gap;
      if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
      gap = send_burst ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_base_year   <= r.year;
      req_base_month  <= r.month;
      req_base_day    <= r.day;
      req_base_hour   <= r.hour;
      req_base_minute <= r.minute;
      req_base_second <= r.second;
      req_add_years   <= r.add_years;
      req_add_months  <= r.add_months;
      req_add_days    <= r.add_days;
      req_add_hours   <= r.add_hours;
      req_add_minutes <= r.add_minutes;
      req_add_seconds <= r.add_seconds;
      req_valid       <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sums.note_request(r);
      requests_sent++;
   endtask

   // hold the request side until every outstanding sum is back
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sums.pending() != 0) @(posedge clock);
   endtask

   initial begin
      datetime_sum_type got;
      int gap;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
         gap = take_burst ? 0 : $urandom_range(0, 18);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got.year     = rsp_sum_year;
         got.month    = rsp_sum_month;
         got.day      = rsp_sum_day;
         got.hour     = rsp_sum_hour;
         got.minute   = rsp_sum_minute;
         got.second   = rsp_sum_second;
         got.overflow = rsp_year_overflow;
         sums.check_sum(got);
      end
   end

   initial begin
      offset_req_type directed[$];
      int i;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      directed.push_back(make_request(0, 1, 1, 0, 0, 0, -1, -1, -1, -1, -1, -1));
      directed.push_back(make_request(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_request(2024, 2, 28, 23, 59, 59, -1, -1, -1, -1, -1, 1));
      directed.push_back(make_request(2023, 2, 28, 23, 59, 59, -1, -1, -1, -1, -1, 1));
      directed.push_back(make_request(1900, 2, 28, 12, 0, 0, -1, -1, 1, -1, -1, -1));
      directed.push_back(make_request(2000, 2, 28, 12, 0, 0, -1, -1, 1, -1, -1, -1));
      directed.push_back(make_request(2100, 2, 29, 0, 0, 0, -1, -1, -1, -1, -1, -1));
      directed.push_back(make_request(1999, 12, 31, 23, 59, 59, -1, -1, -1, -1, -1, 1));
      directed.push_back(make_request(2010, 15, 31, 0, 0, 0, -1, -1, -1, -1, -1, -1));
      directed.push_back(make_request(2021, 2, 31, 0, 0, 0, -1, -1, -1, -1, -1, -1));
      directed.push_back(make_request(2020, 4, 30, 31, 63, 63, -1, -1, -1, -1, -1, -1));
      directed.push_back(make_request(65535, 1, 1, 0, 0, 0, 255, -1, -1, -1, -1, -1));
      directed.push_back(make_request(65535, 12, 31, 23, 59, 59, -1, -1, -1, -1, -1, 1));
      directed.push_back(make_request(65535, 15, 31, 31, 63, 63,
                                      255, 255, 4095, 4095, 65535, 65535));
      directed.push_back(make_request(2015, 6, 15, 10, 20, 30,
                                      -256, -2, -4096, -100, -65536, -2));
      directed.push_back(make_request(2015, 12, 1, 0, 0, 0, 0, 12, 0, 0, 0, 0));
      directed.push_back(make_request(2015, 12, 1, 0, 0, 0, -1, 11, -1, -1, -1, -1));
      directed.push_back(make_request(2019, 11, 30, 0, 0, 0, -1, -1, 1, -1, -1, -1));
      directed.push_back(make_request(2019, 9, 30, 0, 0, 0, -1, -1, 1, -1, -1, -1));
      directed.push_back(make_request(0, 2, 28, 0, 0, 0, -1, -1, 1, -1, -1, -1));
      directed.push_back(make_request(2019, 1, 1, 23, 59, 0, -1, -1, -1, -1, 1, -1));
      directed.push_back(make_request(2019, 1, 1, 0, 0, 0, -1, -1, -1, 24, 60, 60));
      directed.push_back(make_request(0, 1, 1, 0, 0, 0, 0, 0, 4095, 0, 0, 0));

      foreach (directed[k]) send_request(directed[k]);
      hold_until_drained();

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         send_request(random_request());
         if (i == RANDOM_ITEMS / 2) hold_until_drained();
      end
      req_valid <= 1'b0;

      while (sums.pending() != 0) @(posedge clock);
      // longest month walk plus the division steps
      repeat (250) @(posedge clock);

      $display("Sent %0d date-time requests, compared %0d sums, %0d with year overflow.",
               requests_sent, sums.compared, sums.overflows);
      $display("Covered skip codes, leap and century rules, out-of-range bases, long walks.");
      if (sums.mismatches == 0 && sums.pending() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Timed out with %0d sums outstanding.", sums.pending());
      $display("== FAIL ==");
      $finish;
   end

endmodule
